// File: sv/pmaqi_pkg.sv
`default_nettype none

package pmaqi_pkg;

	localparam int ROWS = 16;
	localparam int SEG_W = 4;
	localparam int STAGES = 6;
	localparam int IDX_MAX = 500;
	localparam int RCP_SHIFT = 31;
	localparam int TP_W = 19;
	localparam int RCP_W = 24;
	localparam int PROD_W = TP_W + RCP_W;
	localparam int Q_W = PROD_W - RCP_SHIFT;

	localparam int TAB_COARSE = 0;
	localparam int TAB_FINE = 1;

	// ilo: index at lower bound, di: index span, den3: three times the concentration span,
	// rcp: ceil(2^31 / (2 * concentration span))
	typedef struct packed {
		logic        used;
		logic [8:0]  ilo;
		logic [6:0]  di;
		logic [15:0] clo;
		logic [15:0] chi;
		logic [12:0] den3;
		logic [23:0] rcp;
	} seg_row_t;

	localparam seg_row_t SEG_TAB [2][ROWS] = '{
		'{
			0: '{1'b1, 9'd0,   7'd50, 16'd0,    16'd540,  13'd1620,
				24'((64'd2147483648 + 64'd1079) / 64'd1080)},
			1: '{1'b1, 9'd51,  7'd49, 16'd550,  16'd1540, 13'd2970,
				24'((64'd2147483648 + 64'd1979) / 64'd1980)},
			2: '{1'b1, 9'd101, 7'd49, 16'd1550, 16'd2540, 13'd2970,
				24'((64'd2147483648 + 64'd1979) / 64'd1980)},
			3: '{1'b1, 9'd151, 7'd49, 16'd2550, 16'd3540, 13'd2970,
				24'((64'd2147483648 + 64'd1979) / 64'd1980)},
			4: '{1'b1, 9'd201, 7'd99, 16'd3550, 16'd4240, 13'd2070,
				24'((64'd2147483648 + 64'd1379) / 64'd1380)},
			5: '{1'b1, 9'd301, 7'd99, 16'd4250, 16'd5040, 13'd2370,
				24'((64'd2147483648 + 64'd1579) / 64'd1580)},
			6: '{1'b1, 9'd401, 7'd99, 16'd5050, 16'd6040, 13'd2970,
				24'((64'd2147483648 + 64'd1979) / 64'd1980)},
			default: '0
		},
		'{
			0: '{1'b1, 9'd0,   7'd50, 16'd0,    16'd120,  13'd360,
				24'((64'd2147483648 + 64'd239) / 64'd240)},
			1: '{1'b1, 9'd51,  7'd49, 16'd121,  16'd354,  13'd699,
				24'((64'd2147483648 + 64'd465) / 64'd466)},
			2: '{1'b1, 9'd101, 7'd49, 16'd355,  16'd554,  13'd597,
				24'((64'd2147483648 + 64'd397) / 64'd398)},
			3: '{1'b1, 9'd151, 7'd49, 16'd555,  16'd1504, 13'd2847,
				24'((64'd2147483648 + 64'd1897) / 64'd1898)},
			4: '{1'b1, 9'd201, 7'd99, 16'd1505, 16'd2504, 13'd2997,
				24'((64'd2147483648 + 64'd1997) / 64'd1998)},
			5: '{1'b1, 9'd301, 7'd99, 16'd2505, 16'd3504, 13'd2997,
				24'((64'd2147483648 + 64'd1997) / 64'd1998)},
			6: '{1'b1, 9'd401, 7'd99, 16'd3505, 16'd5004, 13'd4497,
				24'((64'd2147483648 + 64'd2997) / 64'd2998)},
			default: '0
		}
	};

	typedef enum logic [2:0] {
		CAT_GOOD      = 3'd0,
		CAT_MODERATE  = 3'd1,
		CAT_SENSITIVE = 3'd2,
		CAT_UNHEALTHY = 3'd3,
		CAT_VERY      = 3'd4,
		CAT_HAZARDOUS = 3'd5,
		CAT_NONE      = 3'd6
	} cat_t;

	typedef struct packed {
		logic neg;
		logic zero;
		logic above;
	} flag_t;

	typedef struct packed {
		logic [STAGES-1:0] adv;
	} pipe_ctl_t;

endpackage

`default_nettype wire

// File: sv/pmaqi_in_if.sv
`default_nettype none

interface pmaqi_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pm25_tenths;
	logic signed [15:0] pm10_tenths;

	modport source (output valid, output pm25_tenths, output pm10_tenths, input ready);
	modport sink (input valid, input pm25_tenths, input pm10_tenths, output ready);
endinterface

`default_nettype wire

// File: sv/pmaqi_out_if.sv
`default_nettype none

interface pmaqi_out_if;
	logic              valid;
	logic              ready;
	logic signed [9:0] pm25_index;
	logic signed [9:0] pm10_index;
	logic signed [9:0] overall_index;
	logic [2:0]        category;
	logic              overall_valid;

	modport source (output valid, output pm25_index, output pm10_index, output overall_index,
		output category, output overall_valid, input ready);
	modport sink (input valid, input pm25_index, input pm10_index, input overall_index,
		input category, input overall_valid, output ready);
endinterface

`default_nettype wire

// File: sv/pmaqi_sub.sv
`default_nettype none

module pmaqi_sub #(
	parameter int NUM_SEGMENTS = 7,
	parameter int TAB_SEL = 1
) (
	input  wire logic                 clk,
	input  wire pmaqi_pkg::pipe_ctl_t ctl,
	input  wire logic signed [15:0]   conc,
	output logic signed [9:0]         idx
);

	logic [pmaqi_pkg::SEG_W-1:0] hit_seg;
	logic                        found;
	pmaqi_pkg::flag_t            flag_in;

	pmaqi_pkg::flag_t            flag_s1, flag_s2, flag_s3, flag_s4;
	logic [pmaqi_pkg::SEG_W-1:0] seg_s1, seg_s2, seg_s3, seg_s4;
	logic signed [15:0]          conc_s1;
	logic signed [16:0]          d_s2;
	logic [pmaqi_pkg::TP_W-1:0]  tp_s3;
	logic [pmaqi_pkg::RCP_W-1:0] rcp_s3;
	logic [pmaqi_pkg::PROD_W-1:0] prod_s4;
	logic signed [9:0]           idx_s5;

	pmaqi_pkg::seg_row_t         row_s1, row_s2, row_s4;
	logic signed [16:0]          d;
	logic signed [25:0]          tp_full;
	logic [pmaqi_pkg::Q_W-1:0]   q;
	logic signed [13:0]          v;
	logic signed [9:0]           idx_next;

	always_comb begin
		hit_seg = '0;
		found = 1'b0;
		for (int r = pmaqi_pkg::ROWS - 1; r >= 0; r--) begin
			if (pmaqi_pkg::SEG_TAB[TAB_SEL][r].used && r < NUM_SEGMENTS &&
				conc <= $signed(pmaqi_pkg::SEG_TAB[TAB_SEL][r].chi)) begin
				hit_seg = pmaqi_pkg::SEG_W'(r);
				found = 1'b1;
			end
		end
		flag_in.neg = conc[15];
		flag_in.zero = conc <= $signed(pmaqi_pkg::SEG_TAB[TAB_SEL][0].clo);
		flag_in.above = !found;
	end

	assign row_s1 = pmaqi_pkg::SEG_TAB[TAB_SEL][seg_s1];
	assign row_s2 = pmaqi_pkg::SEG_TAB[TAB_SEL][seg_s2];
	assign row_s4 = pmaqi_pkg::SEG_TAB[TAB_SEL][seg_s4];

	assign d = {conc_s1[15], conc_s1} - $signed({1'b0, row_s1.clo});
	assign tp_full = d_s2 * $signed({1'b0, row_s2.di, 1'b0}) + $signed({13'b0, row_s2.den3});
	assign q = prod_s4[pmaqi_pkg::PROD_W-1:pmaqi_pkg::RCP_SHIFT];
	assign v = $signed(14'(row_s4.ilo) + 14'(q) - 14'd1);

	always_comb begin
		priority if (flag_s4.neg) begin
			idx_next = '1;
		end else if (flag_s4.zero) begin
			idx_next = '0;
		end else if (flag_s4.above) begin
			idx_next = 10'(pmaqi_pkg::IDX_MAX);
		end else if (v < 0) begin
			idx_next = '0;
		end else if (v > 14'(pmaqi_pkg::IDX_MAX)) begin
			idx_next = 10'(pmaqi_pkg::IDX_MAX);
		end else begin
			idx_next = v[9:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[0]) begin
			flag_s1 <= flag_in;
			seg_s1 <= hit_seg;
			conc_s1 <= conc;
		end
		if (ctl.adv[1]) begin
			flag_s2 <= flag_s1;
			seg_s2 <= seg_s1;
			d_s2 <= d;
		end
		if (ctl.adv[2]) begin
			flag_s3 <= flag_s2;
			seg_s3 <= seg_s2;
			tp_s3 <= tp_full[pmaqi_pkg::TP_W-1:0];
			rcp_s3 <= row_s2.rcp;
		end
		if (ctl.adv[3]) begin
			flag_s4 <= flag_s3;
			seg_s4 <= seg_s3;
			prod_s4 <= pmaqi_pkg::PROD_W'(tp_s3) * pmaqi_pkg::PROD_W'(rcp_s3);
		end
		if (ctl.adv[4]) begin
			idx_s5 <= idx_next;
		end
	end

	assign idx = idx_s5;

endmodule

`default_nettype wire

// File: sv/pm_air_quality_index_unit.sv
// Throughput: one beat per cycle while the output is not stalled; six register
// stages, the table search in the first and the reciprocal multiply in the fourth.
// A stalled output holds every stage that is full; empty stages still fill.
// Reset (arst_n low) clears all stage valid bits; data registers are not reset.
`default_nettype none

module pm_air_quality_index_unit #(
	parameter int NUM_SEGMENTS = 7
) (
	input wire logic         clk,
	input wire logic         arst_n,
	pmaqi_in_if.sink         sample,
	pmaqi_out_if.source      result
);

	localparam int NS = pmaqi_pkg::STAGES;

	logic [NS-1:0]        vld_q;
	logic [NS-1:0]        rdy;
	pmaqi_pkg::pipe_ctl_t ctl;

	logic signed [9:0]    i25, i10, overall;
	pmaqi_pkg::cat_t      cat;

	logic signed [9:0]    p25_s6, p10_s6, ov_s6;
	pmaqi_pkg::cat_t      cat_s6;
	logic                 ovv_s6;

	always_comb begin
		rdy[NS-1] = !vld_q[NS-1] || result.ready;
		for (int k = NS - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
		ctl.adv[0] = sample.valid && rdy[0];
		for (int k = 1; k < NS; k++) begin
			ctl.adv[k] = vld_q[k-1] && rdy[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= sample.valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	pmaqi_sub #(
		.NUM_SEGMENTS (NUM_SEGMENTS),
		.TAB_SEL      (pmaqi_pkg::TAB_FINE)
	) u_fine (
		.clk  (clk),
		.ctl  (ctl),
		.conc (sample.pm25_tenths),
		.idx  (i25)
	);

	pmaqi_sub #(
		.NUM_SEGMENTS (NUM_SEGMENTS),
		.TAB_SEL      (pmaqi_pkg::TAB_COARSE)
	) u_coarse (
		.clk  (clk),
		.ctl  (ctl),
		.conc (sample.pm10_tenths),
		.idx  (i10)
	);

	assign overall = (i25 > i10) ? i25 : i10;

	always_comb begin
		priority if (overall < 0) begin
			cat = pmaqi_pkg::CAT_NONE;
		end else if (overall <= 10'sd50) begin
			cat = pmaqi_pkg::CAT_GOOD;
		end else if (overall <= 10'sd100) begin
			cat = pmaqi_pkg::CAT_MODERATE;
		end else if (overall <= 10'sd150) begin
			cat = pmaqi_pkg::CAT_SENSITIVE;
		end else if (overall <= 10'sd200) begin
			cat = pmaqi_pkg::CAT_UNHEALTHY;
		end else if (overall <= 10'sd300) begin
			cat = pmaqi_pkg::CAT_VERY;
		end else begin
			cat = pmaqi_pkg::CAT_HAZARDOUS;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[NS-1]) begin
			p25_s6 <= i25;
			p10_s6 <= i10;
			ov_s6 <= overall;
			cat_s6 <= cat;
			ovv_s6 <= !overall[9];
		end
	end

	assign sample.ready = rdy[0];
	assign result.valid = vld_q[NS-1];
	assign result.pm25_index = p25_s6;
	assign result.pm10_index = p10_s6;
	assign result.overall_index = ov_s6;
	assign result.category = cat_s6;
	assign result.overall_valid = ovv_s6;

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> vld_q[0])
		else $error("accepted beat did not enter the first stage");

	a_cat_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.overall_valid == (result.category != pmaqi_pkg::CAT_NONE)))
		else $error("category disagrees with overall_valid");

	a_max: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.overall_valid) |->
		(result.overall_index >= result.pm25_index && result.overall_index >= result.pm10_index))
		else $error("overall index below a sub-index");

	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.overall_valid) |->
		(result.pm25_index == -10'sd1 && result.pm10_index == -10'sd1 &&
		result.overall_index == -10'sd1))
		else $error("no-reading beat carries an index");

endmodule

`default_nettype wire
